@@ rtl/ppp_pkg.sv @@
// Shared types and constants of the planar pose predictor.
package ppp_pkg;

  localparam int AtanEntries = 24;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam int FootRegs = 4;

  typedef enum logic [2:0] {
    CFG_MOVE_GAIN   = 3'd0,
    CFG_ROTATE_GAIN = 3'd1,
    CFG_FOOT_LF     = 3'd2,
    CFG_FOOT_RF     = 3'd3,
    CFG_FOOT_LH     = 3'd4,
    CFG_FOOT_RH     = 3'd5
  } cfg_idx_t;

  // One CORDIC rotation in flight through the cell row.
  typedef struct packed {
    logic               vld;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  // Arctangent of 2^-i as a binary angle in Q32 turn units.
  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] v;
    begin
      case (i)
        5'd0:  v = 34'sh20000000;
        5'd1:  v = 34'sh12E4051E;
        5'd2:  v = 34'sh09FB385B;
        5'd3:  v = 34'sh051111D4;
        5'd4:  v = 34'sh028B0D43;
        5'd5:  v = 34'sh0145D7E1;
        5'd6:  v = 34'sh00A2F61E;
        5'd7:  v = 34'sh00517C55;
        5'd8:  v = 34'sh0028BE53;
        5'd9:  v = 34'sh00145F2F;
        5'd10: v = 34'sh000A2F98;
        5'd11: v = 34'sh000517CC;
        5'd12: v = 34'sh00028BE6;
        5'd13: v = 34'sh000145F3;
        5'd14: v = 34'sh0000A2F9;
        5'd15: v = 34'sh0000517C;
        5'd16: v = 34'sh000028BE;
        5'd17: v = 34'sh0000145F;
        5'd18: v = 34'sh00000A2F;
        5'd19: v = 34'sh00000517;
        5'd20: v = 34'sh0000028B;
        5'd21: v = 34'sh00000145;
        5'd22: v = 34'sh000000A2;
        5'd23: v = 34'sh00000051;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
    begin
      if (v > 36'sd8388607) return 24'sh7FFFFF;
      else if (v < -36'sd8388608) return 24'sh800000;
      else return v[23:0];
    end
  endfunction

endpackage

@@ rtl/ppp_cordic_cell.sv @@
// One rotation-mode CORDIC step with its output register.
module ppp_cordic_cell
  import ppp_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cordic_t cell_in,
  output cordic_t cell_out
);

  cordic_t cell_r, cell_nxt;
  logic signed [33:0] dx, dy;

  always_comb begin
    dx = cell_in.y >>> STEP;
    dy = cell_in.x >>> STEP;
    cell_nxt.vld = cell_in.vld;
    if (!cell_in.z[33]) begin
      cell_nxt.x = cell_in.x - dx;
      cell_nxt.y = cell_in.y + dy;
      cell_nxt.z = cell_in.z - atan_lut(5'(STEP));
    end else begin
      cell_nxt.x = cell_in.x + dx;
      cell_nxt.y = cell_in.y - dy;
      cell_nxt.z = cell_in.z + atan_lut(5'(STEP));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cell_r.vld <= 1'b0;
    else cell_r.vld <= cell_nxt.vld;
    cell_r.x <= cell_nxt.x;
    cell_r.y <= cell_nxt.y;
    cell_r.z <= cell_nxt.z;
  end

  assign cell_out = cell_r;

endmodule

@@ rtl/planar_pose_predictor.sv @@
// Top level of the planar pose predictor: yaw update, CORDIC cell row, pose and foot output.
//
//   channel  ports                                   direction  handshake
//   input    start, busy, in_*                       in         start && !busy
//   result   out_valid, out_*                        out        out_valid, one cycle
//   config   cfg_we, cfg_index, cfg_data             in         cfg_we
//
// An item runs through one yaw stage, CORDIC_ITERATIONS CORDIC cells, a quadrant
// stage, a multiply stage, a sum-and-round stage and a scale-and-saturate stage.
// The body word is registered on the outputs after the scale-and-saturate stage; the
// LEG_COUNT foot words follow, one per cycle. After an acceptance busy stays high
// until the spacing counter has run down, so no new item is taken before then and
// two items never collide at the emitter.
// Reset is synchronous, active low, and clears all valid bits and gains to 1.0.
// The receiver cannot stall; words are shown for exactly one cycle.
module planar_pose_predictor
  import ppp_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int LEG_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_body_x,
  input  logic signed [23:0] in_body_y,
  input  logic signed [23:0] in_body_z,
  input  logic [15:0]        in_body_pitch,
  input  logic [15:0]        in_body_roll,
  input  logic [15:0]        in_body_yaw,
  input  logic signed [23:0] in_move_x,
  input  logic signed [23:0] in_move_y,
  input  logic signed [15:0] in_rotate_yaw,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  output logic               out_valid,
  output logic               out_kind,
  output logic [1:0]         out_leg_index,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic [15:0]        out_pitch,
  output logic [15:0]        out_roll,
  output logic [15:0]        out_yaw,
  output logic               out_last
);

  localparam int Words = LEG_COUNT + 1;
  localparam int CntW = $clog2(Words + 1);

  // Configuration registers.
  logic [15:0] move_gain_r, rotate_gain_r;
  logic [47:0] feet_r [FootRegs];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_gain_r   <= 16'd4096;
      rotate_gain_r <= 16'd4096;
      for (int i = 0; i < FootRegs; i++) feet_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MOVE_GAIN:   move_gain_r <= cfg_data[15:0];
        CFG_ROTATE_GAIN: rotate_gain_r <= cfg_data[15:0];
        CFG_FOOT_LF:     feet_r[0] <= cfg_data;
        CFG_FOOT_RF:     feet_r[1] <= cfg_data;
        CFG_FOOT_LH:     feet_r[2] <= cfg_data;
        CFG_FOOT_RH:     feet_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Spacing counter: the next item waits until the emitter has room.
  logic [CntW-1:0] gap_r, gap_nxt;
  logic accept;
  assign busy = (gap_r != '0);
  assign accept = start && !busy;
  always_comb begin
    gap_nxt = gap_r;
    if (accept) gap_nxt = CntW'(Words - 1);
    else if (gap_r != '0) gap_nxt = gap_r - 1'b1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) gap_r <= '0;
    else gap_r <= gap_nxt;
  end

  // Stage 0: yaw update and capture of the side data.
  typedef struct packed {
    logic signed [23:0] bx, by, bz, mx, my;
    logic [15:0] pitch, roll, yaw;
  } side_t;

  side_t side0_r;
  logic  vld0_r;
  logic signed [32:0] turn_prod;
  logic signed [32:0] turn_q;
  assign turn_prod = $signed({1'b0, rotate_gain_r}) * in_rotate_yaw + 33'sd2048;
  assign turn_q = turn_prod >>> 12;

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else vld0_r <= accept;
    side0_r.bx    <= in_body_x;
    side0_r.by    <= in_body_y;
    side0_r.bz    <= in_body_z;
    side0_r.mx    <= in_move_x;
    side0_r.my    <= in_move_y;
    side0_r.pitch <= in_body_pitch;
    side0_r.roll  <= in_body_roll;
    side0_r.yaw   <= in_body_yaw + turn_q[15:0];
  end

  // CORDIC cell row; side data travels alongside in a matching shift line.
  cordic_t chain [CORDIC_ITERATIONS+1];
  side_t   side_line_r [CORDIC_ITERATIONS];

  assign chain[0] = '{vld: vld0_r, x: CordicGainQ30, y: '0,
                      z: {4'b0, side0_r.yaw[13:0], 16'b0}};

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
    ppp_cordic_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .cell_in(chain[g]), .cell_out(chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    side_line_r[0] <= side0_r;
    for (int i = 1; i < CORDIC_ITERATIONS; i++) side_line_r[i] <= side_line_r[i-1];
  end

  // Stage Q: quadrant mapping.
  cordic_t cend;
  side_t   sq_r;
  logic    vq_r;
  logic signed [33:0] cos_r, sin_r;
  assign cend = chain[CORDIC_ITERATIONS];
  always_ff @(posedge clk) begin
    if (!rst_n) vq_r <= 1'b0;
    else vq_r <= cend.vld;
    sq_r <= side_line_r[CORDIC_ITERATIONS-1];
    case (side_line_r[CORDIC_ITERATIONS-1].yaw[15:14])
      2'd0: begin cos_r <= cend.x;  sin_r <= cend.y;  end
      2'd1: begin cos_r <= -cend.y; sin_r <= cend.x;  end
      2'd2: begin cos_r <= -cend.x; sin_r <= -cend.y; end
      default: begin cos_r <= cend.y; sin_r <= -cend.x; end
    endcase
  end

  // Stage M1: move rotation products (24 x 34 bit each).
  side_t sm1_r;
  logic  vm1_r;
  logic signed [57:0] mxc_r, mys_r, mxs_r, myc_r;
  logic signed [33:0] cos1_r, sin1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vm1_r <= 1'b0;
    else vm1_r <= vq_r;
    sm1_r <= sq_r;
    cos1_r <= cos_r;
    sin1_r <= sin_r;
    mxc_r <= sq_r.mx * cos_r;
    mys_r <= sq_r.my * sin_r;
    mxs_r <= sq_r.mx * sin_r;
    myc_r <= sq_r.my * cos_r;
  end

  // Stage M2: sum and round to the rotated move.
  side_t sm2_r;
  logic  vm2_r;
  logic signed [33:0] cos2_r, sin2_r;
  logic signed [58:0] rxs, rys;
  logic signed [28:0] rx_r, ry_r;
  assign rxs = 59'(mxc_r) - 59'(mys_r) + (59'sd1 <<< 29);
  assign rys = 59'(mxs_r) + 59'(myc_r) + (59'sd1 <<< 29);
  always_ff @(posedge clk) begin
    if (!rst_n) vm2_r <= 1'b0;
    else vm2_r <= vm1_r;
    sm2_r <= sm1_r;
    cos2_r <= cos1_r;
    sin2_r <= sin1_r;
    rx_r <= 29'(rxs >>> 30);
    ry_r <= 29'(rys >>> 30);
  end

  // Stage S: scale by move gain and saturate onto the body position.
  side_t sm3_r;
  logic  vm3_r;
  logic signed [33:0] cos3_r, sin3_r;
  logic signed [23:0] px_r, py_r;
  logic signed [46:0] gx, gy;
  logic signed [35:0] sx, sy;
  assign gx = (47'(rx_r) * $signed({1'b0, move_gain_r}) + 47'sd2048) >>> 12;
  assign gy = (47'(ry_r) * $signed({1'b0, move_gain_r}) + 47'sd2048) >>> 12;
  always_comb begin
    if (gx > 47'sd16777216) sx = 36'sd16777216;
    else if (gx < -47'sd16777216) sx = -36'sd16777216;
    else sx = 36'(gx);
    if (gy > 47'sd16777216) sy = 36'sd16777216;
    else if (gy < -47'sd16777216) sy = -36'sd16777216;
    else sy = 36'(gy);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vm3_r <= 1'b0;
    else vm3_r <= vm2_r;
    sm3_r <= sm2_r;
    cos3_r <= cos2_r;
    sin3_r <= sin2_r;
    px_r <= sat24(36'(sm2_r.bx) + sx);
    py_r <= sat24(36'(sm2_r.by) + sy);
  end

  // Emitter: holds one item's pose and walks the feet, one word per cycle.
  logic [CntW-1:0] word_r, word_nxt;
  logic signed [33:0] cose_r, sine_r;
  logic signed [23:0] pxe_r, pye_r;
  always_comb begin
    word_nxt = word_r;
    if (vm3_r) word_nxt = CntW'(1);
    else if (word_r != '0 && word_r < CntW'(Words)) word_nxt = word_r + 1'b1;
    else word_nxt = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) word_r <= '0;
    else word_r <= word_nxt;
    if (vm3_r) begin
      cose_r <= cos3_r;
      sine_r <= sin3_r;
      pxe_r <= px_r;
      pye_r <= py_r;
    end
  end

  // Foot of the current word: while word_r runs from 1 to LEG_COUNT, foot word_r-1 goes out.
  logic [CntW-1:0] leg_sel;
  logic [47:0] foot;
  logic signed [15:0] fx, fy, fz;
  logic signed [50:0] fxs, fys;
  logic signed [35:0] ox, oy;
  assign leg_sel = word_r - 1'b1;
  always_comb begin
    foot = '0;
    for (int i = 0; i < FootRegs; i++)
      if (i < LEG_COUNT && leg_sel == CntW'(i)) foot = feet_r[i];
  end
  assign fx = foot[15:0];
  assign fy = foot[31:16];
  assign fz = foot[47:32];
  assign fxs = 51'(fx) * 51'(cose_r) - 51'(fy) * 51'(sine_r) + (51'sd1 <<< 21);
  assign fys = 51'(fx) * 51'(sine_r) + 51'(fy) * 51'(cose_r) + (51'sd1 <<< 21);
  assign ox = 36'(pxe_r) + 36'(fxs >>> 22);
  assign oy = 36'(pye_r) + 36'(fys >>> 22);

  // Output register: body word on the cycle after stage S, then foot words.
  logic foot_go;
  assign foot_go = vm3_r || (word_r != '0 && word_r < CntW'(Words));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vm3_r || foot_go;
    end
    if (vm3_r) begin
      out_kind      <= 1'b0;
      out_leg_index <= '0;
      out_pos_x     <= px_r;
      out_pos_y     <= py_r;
      out_pos_z     <= sm3_r.bz;
      out_pitch     <= sm3_r.pitch;
      out_roll      <= sm3_r.roll;
      out_yaw       <= sm3_r.yaw;
      out_last      <= 1'b0;
    end else begin
      out_kind      <= 1'b1;
      out_leg_index <= 2'(leg_sel);
      out_pos_x     <= sat24(ox);
      out_pos_y     <= sat24(oy);
      out_pos_z     <= {fz, 8'b0};
      out_pitch     <= '0;
      out_roll      <= '0;
      out_yaw       <= '0;
      out_last      <= (word_r == CntW'(Words - 1));
    end
  end

  property p_no_overlap;
    @(posedge clk) disable iff (!rst_n) vm3_r |-> (word_r == '0 || word_r == CntW'(Words));
  endproperty
  a_no_overlap: assert property (p_no_overlap) else $error("item overlap at emitter");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (Words > 1) |=> busy) else $error("busy missing after accept");

  a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !(out_valid && out_last)) else $error("double last");

endmodule
